FILE: hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the polynomial continuum subtract core.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int unsigned MAX_BASELINES_DEF = 512;
  localparam int unsigned NUM_CORR_DEF      = 4;
  localparam int unsigned MAX_ORDER_DEF     = 7;

  // configuration write data width (widest register)
  localparam int unsigned CFG_W = 48;

  typedef enum logic [1:0] {
    CFG_MID_FREQ   = 2'd0,
    CFG_FREQ_SCALE = 2'd1,
    CFG_FIT_ORDER  = 2'd2,
    CFG_SUB_MODE   = 2'd3
  } cfg_idx_e;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // complex Q16.16 coefficient
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } coeff_t;

  // Horner accumulator word handed along the cell row
  typedef struct packed {
    logic               vld;
    logic signed [32:0] re;
    logic signed [32:0] im;
  } acc_t;

endpackage

FILE: hdl/pcs_cell.sv
// ----------------------------------------------------------------------------
// pcs_cell
// One Horner cell: multiply by the scaled frequency, round, add its own
// coefficient and saturate, or pass the word unchanged when above the fit order. Holds one coefficient on a shift line.
// ----------------------------------------------------------------------------
module pcs_cell
  import pcs_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned OW  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  coeff_t             coef_i,
  output coeff_t             coef_o,
  input  logic [OW-1:0]      n_i,
  input  logic signed [31:0] sf_i,
  input  acc_t               acc_i,
  output acc_t               acc_o
);

  localparam logic signed [36:0] ACC_HI = 37'sd4294967295;
  localparam logic signed [36:0] ACC_LO = -37'sd4294967296;

  function automatic logic signed [35:0] mul_round(input logic signed [32:0] a,
                                                   input logic signed [31:0] s);
    logic [32:0] ma;
    logic [31:0] ms;
    logic [64:0] t;
    logic [34:0] p;
    ma = a[32] ? 33'(-a) : 33'(a);
    ms = s[31] ? 32'(-s) : 32'(s);
    t  = 65'(ma) * 65'(ms) + 65'(1 << 29);
    p  = t[64:30];
    return (a[32] ^ s[31]) ? -$signed({1'b0, p}) : $signed({1'b0, p});
  endfunction

  function automatic logic signed [32:0] sat33(input logic signed [36:0] v);
    if (v > ACC_HI) begin
      return ACC_HI[32:0];
    end else if (v < ACC_LO) begin
      return ACC_LO[32:0];
    end
    return v[32:0];
  endfunction

  coeff_t             coef_q;
  logic               va_q, act_q;
  logic signed [35:0] pre_q, pim_q;
  logic signed [32:0] rre_q, rim_q;
  acc_t               acc_q;

  assign coef_o = coef_q;
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      coef_q <= coef_i;
    end
    pre_q <= mul_round(acc_i.re, sf_i);
    pim_q <= mul_round(acc_i.im, sf_i);
    rre_q <= acc_i.re;
    rim_q <= acc_i.im;
    act_q <= int'(n_i) > IDX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      va_q      <= acc_i.vld;
      acc_q.vld <= va_q;
      // pass the word unchanged through cells above the fit order
      acc_q.re  <= act_q ? sat33(37'(pre_q) + 37'(coef_q.re)) : rre_q;
      acc_q.im  <= act_q ? sat33(37'(pim_q) + 37'(coef_q.im)) : rim_q;
    end
  end

endmodule

FILE: hdl/polynomial_continuum_subtract_core.sv
// ----------------------------------------------------------------------------
// polynomial_continuum_subtract_core
// Complex polynomial continuum evaluation and subtraction per baseline and
// correlation, with a coefficient store and a row of Horner cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are taken at a rising edge with start high and busy low.
//   func 0 loads one coefficient (order 0 also writes coeff_valid_i to the entry's valid flag);
//   a load is written at the accept edge and leaves busy low.
//   func 1 processes a visibility sample. Coefficients of orders 0..n are
//   read from the store one per cycle (n = fit_order, limited to MAX_ORDER),
//   lowest order first; orders below n are shifted into the cell row and
//   the top coefficient seeds the word that then walks the row, one Horner
//   step in each of the first n cells while the others pass it unchanged.
//   The result follows through the store read port and the cell row; the
//   strobe out_valid_o lasts one cycle and busy drops with it.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   the edge; write only while idle.
//   Reset: registers go to their reset values and the valid store is cleared
//   entry by entry over all MAX_BASELINES*NUM_CORR entries, with busy high.
//   The receiver cannot stall: out_valid_o is high for a single cycle per result.
// ----------------------------------------------------------------------------
module polynomial_continuum_subtract_core
  import pcs_pkg::*;
#(
  parameter int unsigned MAX_BASELINES = MAX_BASELINES_DEF,
  parameter int unsigned NUM_CORR      = NUM_CORR_DEF,
  parameter int unsigned MAX_ORDER     = MAX_ORDER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [8:0]         baseline_i,
  input  logic [1:0]         corr_i,
  input  logic [2:0]         order_i,
  input  logic signed [31:0] coeff_re_i,
  input  logic signed [31:0] coeff_im_i,
  input  logic               coeff_valid_i,
  input  logic [39:0]        chan_freq_i,
  input  logic signed [31:0] vis_re_i,
  input  logic signed [31:0] vis_im_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_re_o,
  output logic signed [31:0] out_im_o,
  output logic               flagged_o
);

  localparam int unsigned NORD  = MAX_ORDER + 1;
  localparam int unsigned NENT  = MAX_BASELINES * NUM_CORR;
  localparam int unsigned EW    = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int unsigned AW    = (NENT * NORD > 1) ? $clog2(NENT * NORD) : 1;
  localparam int unsigned OW    = (NORD > 1) ? $clog2(NORD) : 1;
  localparam int unsigned NCELL = (MAX_ORDER > 0) ? MAX_ORDER : 1;

  localparam logic signed [33:0] Q31_HI = 34'sd2147483647;
  localparam logic signed [33:0] Q31_LO = -34'sd2147483648;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_RUN} state_e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > Q31_HI) begin
      return Q31_HI[31:0];
    end else if (v < Q31_LO) begin
      return Q31_LO[31:0];
    end
    return v[31:0];
  endfunction

  // stores
  coeff_t cmem [NENT*NORD];
  logic   vmem [NENT];

  state_e             state_q;
  logic [EW-1:0]      clr_q;
  logic [39:0]        mid_q;
  logic [47:0]        scale_q;
  logic [2:0]         fit_order_q;
  logic               sub_q;

  logic [EW-1:0]      ent_q;
  logic               inr_q;
  logic [OW-1:0]      n_q, k_q;
  logic signed [31:0] vis_re_q, vis_im_q;
  logic               neg_q;
  logic [39:0]        mag_q;
  logic [63:0]        plo_q, phi_q;
  logic signed [31:0] sf_q;
  coeff_t             rdata_q;
  logic               vrd_q;
  logic               rd_v_q, rd_last_q;
  acc_t               init_q;

  acc_t               chain [NCELL+1];
  coeff_t             cchain [NCELL+1];

  logic               accept, in_range, load_ok;
  logic [31:0]        ent_full;
  logic [EW-1:0]      ent_d;
  logic [AW-1:0]      waddr, raddr;
  logic [OW-1:0]      fit_n;
  logic [40:0]        diff;
  logic [27:0]        frac;
  logic [63:0]        m_sum;
  logic signed [31:0] sf_d;
  logic signed [31:0] res_re, res_im;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // decode the incoming word
  assign in_range = (32'(baseline_i) < MAX_BASELINES) && (32'(corr_i) < NUM_CORR);
  assign ent_full = 32'(baseline_i) * NUM_CORR + 32'(corr_i);
  assign ent_d    = in_range ? ent_full[EW-1:0] : '0;
  assign load_ok  = accept && (func_i == FUNC_LOAD) && in_range
                    && (32'(order_i) <= MAX_ORDER);
  assign waddr    = AW'(ent_full * NORD + 32'(order_i));
  assign raddr    = AW'(32'(ent_q) * NORD + 32'(k_q));
  assign fit_n    = (int'(fit_order_q) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(fit_order_q);

  // frequency offset magnitude, taken at accept
  assign diff = {1'b0, chan_freq_i} - {1'b0, mid_q};

  // combine the two partial products, round half away from zero, saturate
  assign frac  = {phi_q[1:0], 24'b0} + 28'(plo_q[25:0]) + 28'h2000000;
  assign m_sum = (phi_q >> 2) + (plo_q >> 26) + 64'(frac >> 26);
  always_comb begin
    if (neg_q) begin
      sf_d = (m_sum > 64'h80000000) ? 32'sh80000000 : -$signed(m_sum[31:0]);
    end else begin
      sf_d = (m_sum > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(m_sum[31:0]);
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      cmem[waddr] <= '{re: coeff_re_i, im: coeff_im_i};
    end
    if (state_q == S_CLEAR) begin
      vmem[clr_q] <= 1'b0;
    end else if (load_ok && (order_i == 3'd0)) begin
      vmem[ent_d] <= coeff_valid_i;
    end
    rdata_q <= cmem[raddr];
    vrd_q   <= vmem[ent_q];
  end

  // scaled frequency pipeline: partial products, then sum
  always_ff @(posedge clk_i) begin
    plo_q <= 64'(mag_q) * 64'(scale_q[23:0]);
    phi_q <= 64'(mag_q) * 64'(scale_q[47:24]);
    sf_q  <= sf_d;
  end

  // cell row
  assign chain[0]  = init_q;
  assign cchain[0] = rdata_q;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    pcs_cell #(
      .IDX (j),
      .OW  (OW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (rd_v_q && !rd_last_q),
      .coef_i  (cchain[j]),
      .coef_o  (cchain[j+1]),
      .n_i     (n_q),
      .sf_i    (sf_q),
      .acc_i   (chain[j]),
      .acc_o   (chain[j+1])
    );
  end

  // result selection
  always_comb begin
    if (sub_q) begin
      res_re = sat32(34'(vis_re_q) - 34'(chain[NCELL].re));
      res_im = sat32(34'(vis_im_q) - 34'(chain[NCELL].im));
    end else begin
      res_re = sat32(34'(chain[NCELL].re));
      res_im = sat32(34'(chain[NCELL].im));
    end
  end

  // control, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mid_q       <= '0;
      scale_q     <= '0;
      fit_order_q <= '0;
      sub_q       <= 1'b1;
      ent_q       <= '0;
      inr_q       <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      vis_re_q    <= '0;
      vis_im_q    <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      init_q      <= '0;
      out_valid_o <= 1'b0;
      out_re_o    <= '0;
      out_im_o    <= '0;
      flagged_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MID_FREQ:   mid_q       <= cfg_data_i[39:0];
          CFG_FREQ_SCALE: scale_q     <= cfg_data_i[47:0];
          CFG_FIT_ORDER:  fit_order_q <= cfg_data_i[2:0];
          CFG_SUB_MODE:   sub_q       <= cfg_data_i[0];
          default:        ;
        endcase
      end

      out_valid_o <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      init_q.vld  <= 1'b0;

      // seed the row with the top-order coefficient
      if (rd_v_q && rd_last_q) begin
        init_q <= '{vld: 1'b1, re: 33'(rdata_q.re), im: 33'(rdata_q.im)};
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == EW'(NENT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (func_i == FUNC_SAMPLE)) begin
            ent_q    <= ent_d;
            inr_q    <= in_range;
            n_q      <= fit_n;
            k_q      <= '0;
            vis_re_q <= vis_re_i;
            vis_im_q <= vis_im_i;
            neg_q    <= diff[40];
            mag_q    <= diff[40] ? 40'(-diff) : diff[39:0];
            state_q  <= S_READ;
          end
        end
        S_READ: begin
          // issue one coefficient read per cycle, lowest order first
          rd_v_q    <= 1'b1;
          rd_last_q <= (k_q == n_q);
          k_q       <= k_q + 1'b1;
          if (k_q == n_q) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (chain[NCELL].vld) begin
            out_valid_o <= 1'b1;
            if (inr_q && vrd_q) begin
              out_re_o  <= res_re;
              out_im_o  <= res_im;
              flagged_o <= 1'b0;
            end else begin
              out_re_o  <= vis_re_q;
              out_im_o  <= vis_im_q;
              flagged_o <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the polynomial continuum subtract core.
// ----------------------------------------------------------------------------
module pcs_checker
  import pcs_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic func_i,
  input logic out_valid_o
);

  // a sample accept raises busy
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == FUNC_SAMPLE) |=> busy)
    else $error("sample accept did not raise busy");

  // a load completes at once
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == FUNC_LOAD) |=> !busy)
    else $error("load raised busy");

  // result strobe ends the busy period
  a_strobe_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy && $past(busy))
    else $error("result strobe outside busy end");

  // one strobe per sample
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind polynomial_continuum_subtract_core pcs_checker u_pcs_checker (.*);
